// ===== rtl/dcfb8_pkg.sv =====
// Package for the DES CFB-8 byte cipher unit: DES tables, register index codes
// and the combinational DES block function. Used by des_cfb8_byte_cipher_unit.
`default_nettype none
package dcfb8_pkg;

  localparam int unsigned KeyW  = 64;
  localparam int unsigned ByteW = 8;
  localparam int unsigned IdxW  = 2;

  localparam logic [IdxW-1:0] REG_CIPHER_KEY   = 2'd0;
  localparam logic [IdxW-1:0] REG_DECRYPT_MODE = 2'd1;

  typedef logic [6:0] pos_t;

  localparam pos_t TAB_IP [64] = '{
    58,50,42,34,26,18,10,2, 60,52,44,36,28,20,12,4,
    62,54,46,38,30,22,14,6, 64,56,48,40,32,24,16,8,
    57,49,41,33,25,17,9,1, 59,51,43,35,27,19,11,3,
    61,53,45,37,29,21,13,5, 63,55,47,39,31,23,15,7};
  localparam pos_t TAB_FP [64] = '{
    40,8,48,16,56,24,64,32, 39,7,47,15,55,23,63,31,
    38,6,46,14,54,22,62,30, 37,5,45,13,53,21,61,29,
    36,4,44,12,52,20,60,28, 35,3,43,11,51,19,59,27,
    34,2,42,10,50,18,58,26, 33,1,41,9,49,17,57,25};
  localparam pos_t TAB_E [48] = '{
    32,1,2,3,4,5, 4,5,6,7,8,9, 8,9,10,11,12,13, 12,13,14,15,16,17,
    16,17,18,19,20,21, 20,21,22,23,24,25, 24,25,26,27,28,29, 28,29,30,31,32,1};
  localparam pos_t TAB_P [32] = '{
    16,7,20,21,29,12,28,17, 1,15,23,26,5,18,31,10,
    2,8,24,14,32,27,3,9, 19,13,30,6,22,11,4,25};
  localparam pos_t TAB_PC1 [56] = '{
    57,49,41,33,25,17,9, 1,58,50,42,34,26,18, 10,2,59,51,43,35,27,
    19,11,3,60,52,44,36, 63,55,47,39,31,23,15, 7,62,54,46,38,30,22,
    14,6,61,53,45,37,29, 21,13,5,28,20,12,4};
  localparam pos_t TAB_PC2 [48] = '{
    14,17,11,24,1,5, 3,28,15,6,21,10, 23,19,12,4,26,8, 16,7,27,20,13,2,
    41,52,31,37,47,55, 30,40,51,45,33,48, 44,49,39,56,34,53, 46,42,50,36,29,32};
  localparam logic [1:0] TAB_ROT [16] = '{1,1,2,2,2,2,2,2,1,2,2,2,2,2,2,1};
  localparam logic [3:0] TAB_S [8][64] = '{
   '{14,4,13,1,2,15,11,8,3,10,6,12,5,9,0,7, 0,15,7,4,14,2,13,1,10,6,12,11,9,5,3,8,
     4,1,14,8,13,6,2,11,15,12,9,7,3,10,5,0, 15,12,8,2,4,9,1,7,5,11,3,14,10,0,6,13},
   '{15,1,8,14,6,11,3,4,9,7,2,13,12,0,5,10, 3,13,4,7,15,2,8,14,12,0,1,10,6,9,11,5,
     0,14,7,11,10,4,13,1,5,8,12,6,9,3,2,15, 13,8,10,1,3,15,4,2,11,6,7,12,0,5,14,9},
   '{10,0,9,14,6,3,15,5,1,13,12,7,11,4,2,8, 13,7,0,9,3,4,6,10,2,8,5,14,12,11,15,1,
     13,6,4,9,8,15,3,0,11,1,2,12,5,10,14,7, 1,10,13,0,6,9,8,7,4,15,14,3,11,5,2,12},
   '{7,13,14,3,0,6,9,10,1,2,8,5,11,12,4,15, 13,8,11,5,6,15,0,3,4,7,2,12,1,10,14,9,
     10,6,9,0,12,11,7,13,15,1,3,14,5,2,8,4, 3,15,0,6,10,1,13,8,9,4,5,11,12,7,2,14},
   '{2,12,4,1,7,10,11,6,8,5,3,15,13,0,14,9, 14,11,2,12,4,7,13,1,5,0,15,10,3,9,8,6,
     4,2,1,11,10,13,7,8,15,9,12,5,6,3,0,14, 11,8,12,7,1,14,2,13,6,15,0,9,10,4,5,3},
   '{12,1,10,15,9,2,6,8,0,13,3,4,14,7,5,11, 10,15,4,2,7,12,9,5,6,1,13,14,0,11,3,8,
     9,14,15,5,2,8,12,3,7,0,4,10,1,13,11,6, 4,3,2,12,9,5,15,10,11,14,1,7,6,0,8,13},
   '{4,11,2,14,15,0,8,13,3,12,9,7,5,10,6,1, 13,0,11,7,4,9,1,10,14,3,5,12,2,15,8,6,
     1,4,11,13,12,3,7,14,10,15,6,8,0,5,9,2, 6,11,13,8,1,4,10,7,9,5,0,15,14,2,3,12},
   '{13,2,8,4,6,15,11,1,10,9,3,14,5,0,12,7, 1,15,13,8,10,3,7,4,12,5,6,11,0,14,9,2,
     7,11,4,1,9,12,14,2,0,6,10,13,15,3,5,8, 2,1,14,7,4,10,8,13,15,12,9,0,3,5,6,11}};

  // Bit positions count from the MSB, starting at one.
  function automatic logic [63:0] perm_ip(input logic [63:0] v);
    logic [63:0] r;
    for (int i = 0; i < 64; i++) r[63-i] = v[6'(7'd64 - TAB_IP[i])];
    return r;
  endfunction

  function automatic logic [63:0] perm_fp(input logic [63:0] v);
    logic [63:0] r;
    for (int i = 0; i < 64; i++) r[63-i] = v[6'(7'd64 - TAB_FP[i])];
    return r;
  endfunction

  function automatic logic [55:0] perm_pc1(input logic [63:0] v);
    logic [55:0] r;
    for (int i = 0; i < 56; i++) r[55-i] = v[6'(7'd64 - TAB_PC1[i])];
    return r;
  endfunction

  function automatic logic [47:0] perm_pc2(input logic [55:0] v);
    logic [47:0] r;
    for (int i = 0; i < 48; i++) r[47-i] = v[6'(7'd56 - TAB_PC2[i])];
    return r;
  endfunction

  function automatic logic [27:0] rot28(input logic [27:0] v, input logic [1:0] s);
    logic [27:0] r;
    r = (s == 2'd1) ? {v[26:0], v[27]} : {v[25:0], v[27:26]};
    return r;
  endfunction

  function automatic logic [31:0] round_fn(input logic [31:0] r, input logic [47:0] sub);
    logic [47:0] x;
    logic [5:0]  b;
    logic [31:0] o;
    logic [31:0] p;
    for (int i = 0; i < 48; i++) x[47-i] = r[5'(7'd32 - TAB_E[i])];
    x = x ^ sub;
    for (int i = 0; i < 8; i++) begin
      b = x[47-6*i -: 6];
      o[31-4*i -: 4] = TAB_S[i][{b[5], b[0], b[4:1]}];
    end
    for (int i = 0; i < 32; i++) p[31-i] = o[5'(7'd32 - TAB_P[i])];
    return p;
  endfunction

  function automatic logic [63:0] des_block_encrypt(input logic [63:0] key,
                                                    input logic [63:0] blk);
    logic [55:0] cd;
    logic [27:0] c;
    logic [27:0] d;
    logic [63:0] b;
    logic [31:0] l;
    logic [31:0] r;
    logic [31:0] t;
    cd = perm_pc1(key);
    c  = cd[55:28];
    d  = cd[27:0];
    b  = perm_ip(blk);
    l  = b[63:32];
    r  = b[31:0];
    for (int i = 0; i < 16; i++) begin
      c = rot28(c, TAB_ROT[i]);
      d = rot28(d, TAB_ROT[i]);
      t = l ^ round_fn(r, perm_pc2({c, d}));
      l = r;
      r = t;
    end
    return perm_fp({r, l});
  endfunction

endpackage
`default_nettype wire

// ===== rtl/des_cfb8_byte_cipher_unit.sv =====
// DES CFB-8 byte cipher unit, top level.
// Depends on dcfb8_pkg for the DES tables and block function.
//
// Usage:
//   Write cipher_key (index 0) and decrypt_mode (index 1) on the cfg port
//   while the unit is idle. Then stream bytes on the input valid/ready
//   channel; each word carries a data byte and a last flag. Each word gives
//   one output word with the XORed byte and a copy of the flag.
//   The output word is valid in the cycle after input accept. Throughput: one
//   byte per cycle while the receiver takes each word; the full 16-round DES on
//   the feedback register is combinational between the feedback register and the
//   output register, and that path sets the clock rate.
//   The feedback register starts at zero and returns to zero after a word
//   flagged last. Reset clears key, mode, feedback and the output valid.
//   When the receiver stalls, the output word holds and the input is taken
//   only in the cycle the held word leaves.
`default_nettype none
module des_cfb8_byte_cipher_unit (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        cfg_we_i,
  input  wire logic [dcfb8_pkg::IdxW-1:0]  cfg_index_i,
  input  wire logic [dcfb8_pkg::KeyW-1:0]  cfg_data_i,
  input  wire logic                        in_valid_i,
  output logic                             in_ready_o,
  input  wire logic [dcfb8_pkg::ByteW-1:0] data_byte_i,
  input  wire logic                        last_byte_i,
  output logic                             out_valid_o,
  input  wire logic                        out_ready_i,
  output logic [dcfb8_pkg::ByteW-1:0]      result_byte_o,
  output logic                             result_last_o
);

  logic [dcfb8_pkg::KeyW-1:0]  key_q;
  logic                        decrypt_q;
  logic [63:0]                 feedback_q, feedback_d;
  logic                        out_valid_q;
  logic [dcfb8_pkg::ByteW-1:0] result_byte_q, result_byte_d;
  logic                        result_last_q;
  logic [63:0]                 pad_block;
  logic                        in_accept;
  logic [dcfb8_pkg::ByteW-1:0] cipher_byte;

  assign in_ready_o = !out_valid_q || out_ready_i;
  assign in_accept  = in_valid_i && in_ready_o;

  assign pad_block     = dcfb8_pkg::des_block_encrypt(key_q, feedback_q);
  assign result_byte_d = data_byte_i ^ pad_block[63:56];
  assign cipher_byte   = decrypt_q ? data_byte_i : result_byte_d;
  // drop the history once a message ends
  assign feedback_d    = last_byte_i ? 64'd0 : {feedback_q[55:0], cipher_byte};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_q       <= '0;
      decrypt_q   <= 1'b0;
      feedback_q  <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_index_i)
          dcfb8_pkg::REG_CIPHER_KEY:   key_q     <= cfg_data_i;
          dcfb8_pkg::REG_DECRYPT_MODE: decrypt_q <= cfg_data_i[0];
          default: ;
        endcase
      end
      if (in_accept) begin
        feedback_q  <= feedback_d;
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      result_byte_q <= result_byte_d;
      result_last_q <= last_byte_i;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign result_byte_o = result_byte_q;
  assign result_last_o = result_last_q;

`ifndef SYNTHESIS
  a_valid_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_accept |=> out_valid_o) else $error("no output word after accept");
  a_clear_after_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_accept && last_byte_i) |=> (feedback_q == 64'd0))
    else $error("feedback not cleared after last word");
  a_ready_when_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_q |-> in_ready_o) else $error("input stalled with empty output");
  a_feedback_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_accept |=> $stable(feedback_q)) else $error("feedback moved without accept");
`endif

endmodule
`default_nettype wire
